// ----- rtl/core/escp_pkg.sv -----
// Package for the expert slot cache policy block.
// Sizes, status and register codes, sequencer states and the store control struct.
// No dependencies.
package escp_pkg;

   localparam int SLOT_CAP       = 512;
   localparam int GROUP_SIZE     = 32;
   localparam int MAX_EXPERT_IDS = 1024;
   localparam int MIN_AUTO_SLOTS = 8;

   localparam int SLOT_W     = $clog2(SLOT_CAP);           // slot index within a table
   localparam int COUNT_W    = $clog2(SLOT_CAP) + 1;       // slot count, holds SLOT_CAP
   localparam int ID_W       = $clog2(MAX_EXPERT_IDS);
   localparam int SADDR_W    = SLOT_W + 1;                 // projection + slot
   localparam int MADDR_W    = ID_W + 1;                   // projection + expert
   localparam int OWNER_W    = ID_W + 1;                   // occupied flag + expert
   localparam int STAMP_W    = 64;
   localparam int LAYER_W    = 5;
   localparam int LOCAL_W    = $clog2(GROUP_SIZE);
   localparam int CFG_W      = 10;
   localparam int CFG_ADDR_W = 2;
   localparam int NL_W       = 6;
   localparam int TOTAL_W    = 2 * NL_W;

   localparam logic [CFG_ADDR_W-1:0] REG_ENABLE   = 2'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_NUM_LAY  = 2'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_EXP_PER  = 2'd2;
   localparam logic [CFG_ADDR_W-1:0] REG_RES_REQ  = 2'd3;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_EVICT  = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_SCAN,
      S_SCAN_END,
      S_LOOKUP,
      S_EVAL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [SADDR_W-1:0] slot_rd_addr;
      logic [MADDR_W-1:0] map_rd_addr;
      logic               owner_we;
      logic               stamp_we;
      logic [SADDR_W-1:0] slot_wr_addr;
      logic [OWNER_W-1:0] owner_wdata;
      logic [STAMP_W-1:0] stamp_wdata;
      logic               map_we;
      logic [MADDR_W-1:0] map_wr_addr;
      logic [SLOT_W-1:0]  map_wdata;
      logic               valid_we;
      logic [MADDR_W-1:0] valid_wr_addr;
      logic               valid_wdata;
   } store_ctrl_type;

endpackage

// ----- rtl/core/escp_if.sv -----
// Request and response channel interfaces for the expert slot cache policy block.
// Depends on escp_pkg.
interface escp_req_if;
   logic                       valid;
   logic                       ready;
   logic [escp_pkg::LAYER_W-1:0] layer;
   logic [escp_pkg::ID_W-1:0]  expert;
   logic                       projection;

   modport source (output valid, layer, expert, projection, input ready);
   modport sink   (input valid, layer, expert, projection, output ready);
endinterface

interface escp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [escp_pkg::SLOT_W-1:0] slot;
   logic [escp_pkg::ID_W-1:0]   evicted_expert;
   logic                        used_fallback;

   modport source (output valid, status, slot, evicted_expert, used_fallback, input ready);
   modport sink   (input valid, status, slot, evicted_expert, used_fallback, output ready);
endinterface

// ----- rtl/core/escp_scan.sv -----
// Shared search unit: first empty slot, else least stamp (lowest index on ties).
// Depends on escp_pkg.
module escp_scan (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          strobe,
   input  logic [escp_pkg::SLOT_W-1:0]   idx,
   input  logic                          occupied,
   input  logic [escp_pkg::STAMP_W-1:0]  stamp,
   output logic [escp_pkg::SLOT_W-1:0]   chosen
);
   logic                         have_empty_ff, have_empty_in;
   logic                         first_ff, first_in;
   logic [escp_pkg::SLOT_W-1:0]  empty_idx_ff, empty_idx_in;
   logic [escp_pkg::SLOT_W-1:0]  best_idx_ff, best_idx_in;
   logic [escp_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   always_comb begin
      have_empty_in = have_empty_ff;
      first_in      = first_ff;
      empty_idx_in  = empty_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      if (start) begin
         have_empty_in = 1'b0;
         first_in      = 1'b1;
      end else if (strobe) begin
         first_in = 1'b0;
         if (!occupied && !have_empty_ff) begin
            have_empty_in = 1'b1;
            empty_idx_in  = idx;
         end
         // strict less-than keeps the lowest index on equal stamps
         if (first_ff || (stamp < best_stamp_ff)) begin
            best_stamp_in = stamp;
            best_idx_in   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      have_empty_ff <= have_empty_in;
      first_ff      <= first_in;
      empty_idx_ff  <= empty_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign chosen = have_empty_ff ? empty_idx_ff : best_idx_ff;
endmodule

// ----- rtl/core/escp_store.sv -----
// Slot owner, slot stamp, expert map and map valid memories, registered reads.
// Depends on escp_pkg.
module escp_store (
   input  logic                           clock,
   input  escp_pkg::store_ctrl_type       ctl,
   output logic [escp_pkg::OWNER_W-1:0]   owner_q,
   output logic [escp_pkg::STAMP_W-1:0]   stamp_q,
   output logic [escp_pkg::SLOT_W-1:0]    map_q,
   output logic                           valid_q
);
   localparam int SDEPTH = 2 * escp_pkg::SLOT_CAP;
   localparam int MDEPTH = 2 * escp_pkg::MAX_EXPERT_IDS;

   logic [escp_pkg::OWNER_W-1:0] owner_mem [SDEPTH];
   logic [escp_pkg::STAMP_W-1:0] stamp_mem [SDEPTH];
   logic [escp_pkg::SLOT_W-1:0]  map_mem   [MDEPTH];
   logic                         valid_mem [MDEPTH];

   always_ff @(posedge clock) begin
      if (ctl.owner_we) begin
         owner_mem[ctl.slot_wr_addr] <= ctl.owner_wdata;
      end
      owner_q <= owner_mem[ctl.slot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.stamp_we) begin
         stamp_mem[ctl.slot_wr_addr] <= ctl.stamp_wdata;
      end
      stamp_q <= stamp_mem[ctl.slot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.map_we) begin
         map_mem[ctl.map_wr_addr] <= ctl.map_wdata;
      end
      map_q <= map_mem[ctl.map_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.valid_we) begin
         valid_mem[ctl.valid_wr_addr] <= ctl.valid_wdata;
      end
      valid_q <= valid_mem[ctl.map_rd_addr];
   end
endmodule

// ----- rtl/core/expert_slot_cache_policy_top.sv -----
// Expert slot cache policy: top level with sequencer, registers and output stage.
// Direct slot: accept, then prep, lookup, eval and done, then the registered result;
// overflow adds scan and scan_end, one slot read per cycle through the shared search unit.
// One beat at a time; idle, and so the next accept, comes as the result is loaded into the
// output stage; a rejected beat goes from prep straight to done; output stalls hold done.
// Reset: synchronous; a clearing pass over 2*MAX_EXPERT_IDS (2048) entries empties slots,
// stamps and map valid bits, during which no beat is accepted. Config writes always taken.
module expert_slot_cache_policy_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [escp_pkg::CFG_ADDR_W-1:0]     csr_addr,
   input  logic [escp_pkg::CFG_W-1:0]          csr_wdata,
   escp_req_if.sink                            req_ch,
   escp_rsp_if.source                          rsp_ch
);
   localparam logic [escp_pkg::COUNT_W-1:0] MAX_COUNT = escp_pkg::COUNT_W'(escp_pkg::SLOT_CAP);

   // configuration
   logic                          enable_ff;
   logic [escp_pkg::NL_W-1:0]     num_layers_ff;
   logic [escp_pkg::NL_W-1:0]     exp_per_ff;
   logic [escp_pkg::CFG_W-1:0]    res_req_ff;
   logic [escp_pkg::TOTAL_W-1:0]  total_ff;

   // sequencer
   escp_pkg::state_type           state_ff, state_in;
   logic [escp_pkg::MADDR_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [escp_pkg::COUNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic                          issue_ff;
   logic [escp_pkg::SLOT_W-1:0]   issue_idx_ff;

   // beat in flight
   logic [escp_pkg::LAYER_W-1:0]  layer_ff, layer_in;
   logic [escp_pkg::ID_W-1:0]     expert_ff, expert_in;
   logic                          proj_ff, proj_in;
   logic [escp_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          fallback_ff, fallback_in;
   logic [1:0]                    status_ff, status_in;
   logic [escp_pkg::ID_W-1:0]     evicted_ff, evicted_in;
   logic [escp_pkg::STAMP_W-1:0]  counter_ff, counter_in;

   // output stage
   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_status_ff;
   logic [escp_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [escp_pkg::ID_W-1:0]     rsp_evicted_ff;
   logic                          rsp_fallback_ff;

   escp_pkg::store_ctrl_type      ctl;
   logic [escp_pkg::OWNER_W-1:0]  owner_q;
   logic [escp_pkg::STAMP_W-1:0]  stamp_q;
   logic [escp_pkg::SLOT_W-1:0]   map_q;
   logic                          valid_q;
   logic [escp_pkg::SLOT_W-1:0]   scan_slot;

   logic [escp_pkg::TOTAL_W-1:0]  half_total, auto_want, want;
   logic [escp_pkg::COUNT_W-1:0]  count;
   logic [escp_pkg::COUNT_W-1:0]  pref_slot;
   logic [escp_pkg::SLOT_W-1:0]   look_slot;
   logic [escp_pkg::ID_W-1:0]     old_id;
   logic                          reject, accept, out_load, hit, slot_busy;

   // ---------------------------------------------------------------
   // Config registers; total expert count registered off the multiply
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         num_layers_ff <= escp_pkg::NL_W'(24);
         exp_per_ff    <= escp_pkg::NL_W'(32);
         res_req_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            escp_pkg::REG_ENABLE:  enable_ff     <= csr_wdata[0];
            escp_pkg::REG_NUM_LAY: num_layers_ff <= csr_wdata[escp_pkg::NL_W-1:0];
            escp_pkg::REG_EXP_PER: exp_per_ff    <= csr_wdata[escp_pkg::NL_W-1:0];
            escp_pkg::REG_RES_REQ: res_req_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= escp_pkg::TOTAL_W'(num_layers_ff) * escp_pkg::TOTAL_W'(exp_per_ff);
   end

   // effective slot count: auto rule, cap at total, saturate at the slot cap
   always_comb begin
      half_total = total_ff >> 1;
      auto_want  = (half_total < escp_pkg::TOTAL_W'(escp_pkg::MIN_AUTO_SLOTS))
                   ? escp_pkg::TOTAL_W'(escp_pkg::MIN_AUTO_SLOTS) : half_total;
      want       = (res_req_ff == '0) ? auto_want : escp_pkg::TOTAL_W'(res_req_ff);
      if (want > total_ff) begin
         want = total_ff;
      end
      count = (want > escp_pkg::TOTAL_W'(MAX_COUNT)) ? MAX_COUNT
              : want[escp_pkg::COUNT_W-1:0];
   end

   assign pref_slot = {layer_ff, expert_ff[escp_pkg::LOCAL_W-1:0]};
   assign reject    = !enable_ff || ({1'b0, layer_ff} >= num_layers_ff) || (count == '0);
   assign look_slot = fallback_ff ? scan_slot : slot_ff;
   assign old_id    = owner_q[escp_pkg::ID_W-1:0];
   assign hit       = valid_q && (map_q == slot_ff);
   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_busy = rsp_valid_ff && !rsp_ch.ready;
   assign out_load  = (state_ff == escp_pkg::S_DONE) && !slot_busy;

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         escp_pkg::S_CLEAR:    if (clr_idx_ff == '1) state_in = escp_pkg::S_IDLE;
         escp_pkg::S_IDLE:     if (accept) state_in = escp_pkg::S_PREP;
         escp_pkg::S_PREP: begin
            if (reject) begin
               state_in = escp_pkg::S_DONE;
            end else if (pref_slot >= count) begin
               state_in = escp_pkg::S_SCAN;
            end else begin
               state_in = escp_pkg::S_LOOKUP;
            end
         end
         escp_pkg::S_SCAN:     if (scan_idx_ff == count - 1'b1) state_in = escp_pkg::S_SCAN_END;
         escp_pkg::S_SCAN_END: state_in = escp_pkg::S_LOOKUP;
         escp_pkg::S_LOOKUP:   state_in = escp_pkg::S_EVAL;
         // a miss comes back through DONE only after the map valid bit is set
         escp_pkg::S_EVAL:     state_in = escp_pkg::S_DONE;
         escp_pkg::S_DONE:     if (!slot_busy) state_in = escp_pkg::S_IDLE;
         default:              state_in = escp_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Outputs of the sequencer: store control and datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      ctl          = '0;
      ctl.slot_rd_addr = {proj_ff, look_slot};
      ctl.map_rd_addr  = {proj_ff, expert_ff};
      clr_idx_in   = clr_idx_ff;
      scan_idx_in  = scan_idx_ff;
      layer_in     = layer_ff;
      expert_in    = expert_ff;
      proj_in      = proj_ff;
      slot_in      = slot_ff;
      fallback_in  = fallback_ff;
      status_in    = status_ff;
      evicted_in   = evicted_ff;
      counter_in   = counter_ff;
      case (state_ff)
         escp_pkg::S_CLEAR: begin
            ctl.owner_we      = 1'b1;
            ctl.stamp_we      = 1'b1;
            ctl.slot_wr_addr  = clr_idx_ff[escp_pkg::SADDR_W-1:0];
            ctl.valid_we      = 1'b1;
            ctl.valid_wr_addr = clr_idx_ff;
            clr_idx_in        = clr_idx_ff + 1'b1;
         end
         escp_pkg::S_IDLE: begin
            if (accept) begin
               layer_in  = req_ch.layer;
               expert_in = req_ch.expert;
               proj_in   = req_ch.projection;
            end
         end
         escp_pkg::S_PREP: begin
            scan_idx_in = '0;
            evicted_in  = '0;
            if (reject) begin
               status_in   = escp_pkg::ST_REJECT;
               slot_in     = '0;
               fallback_in = 1'b0;
            end else if (pref_slot >= count) begin
               fallback_in = 1'b1;
            end else begin
               slot_in     = pref_slot[escp_pkg::SLOT_W-1:0];
               fallback_in = 1'b0;
            end
         end
         escp_pkg::S_SCAN: begin
            ctl.slot_rd_addr = {proj_ff, scan_idx_ff[escp_pkg::SLOT_W-1:0]};
            scan_idx_in      = scan_idx_ff + 1'b1;
         end
         escp_pkg::S_LOOKUP: begin
            slot_in = look_slot;
         end
         escp_pkg::S_EVAL: begin
            counter_in       = counter_ff + 1'b1;
            ctl.stamp_we     = 1'b1;
            ctl.slot_wr_addr = {proj_ff, slot_ff};
            ctl.stamp_wdata  = counter_ff + 1'b1;
            if (hit) begin
               status_in = escp_pkg::ST_HIT;
            end else begin
               ctl.owner_we    = 1'b1;
               ctl.owner_wdata = {1'b1, expert_ff};
               ctl.map_we      = 1'b1;
               ctl.map_wr_addr = {proj_ff, expert_ff};
               ctl.map_wdata   = slot_ff;
               ctl.valid_we      = 1'b1;
               ctl.valid_wr_addr = {proj_ff, expert_ff};
               ctl.valid_wdata   = 1'b1;
               if (owner_q[escp_pkg::ID_W]) begin
                  status_in  = escp_pkg::ST_EVICT;
                  evicted_in = old_id;
               end else begin
                  status_in = escp_pkg::ST_EMPTY;
               end
            end
         end
         escp_pkg::S_DONE: begin
            // previous occupant loses its map entry; new entry was set in EVAL
            // unless it is the same expert, which is then left as just written
         end
         default: ;
      endcase
   end

   // Clearing the old occupant's entry must not collide with setting the new one;
   // ids differ there, so the two bits sit at different addresses; set in EVAL, cleared in DONE.
   logic clear_old_ff;
   logic [escp_pkg::ID_W-1:0] clear_id_ff;
   escp_pkg::store_ctrl_type  ctl_m;

   always_comb begin
      ctl_m = ctl;
      if ((state_ff == escp_pkg::S_DONE) && clear_old_ff) begin
         ctl_m.valid_we      = 1'b1;
         ctl_m.valid_wr_addr = {proj_ff, clear_id_ff};
         ctl_m.valid_wdata   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_old_ff <= 1'b0;
      end else if (state_ff == escp_pkg::S_EVAL) begin
         clear_old_ff <= !hit && owner_q[escp_pkg::ID_W] && (old_id != expert_ff);
      end else if (state_ff == escp_pkg::S_DONE) begin
         clear_old_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == escp_pkg::S_EVAL) begin
         clear_id_ff <= old_id;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= escp_pkg::S_CLEAR;
         clr_idx_ff  <= '0;
         counter_ff  <= '0;
         issue_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_idx_ff  <= clr_idx_in;
         counter_ff  <= counter_in;
         issue_ff    <= (state_ff == escp_pkg::S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      issue_idx_ff <= scan_idx_ff[escp_pkg::SLOT_W-1:0];
      layer_ff     <= layer_in;
      expert_ff    <= expert_in;
      proj_ff      <= proj_in;
      slot_ff      <= slot_in;
      fallback_ff  <= fallback_in;
      status_ff    <= status_in;
      evicted_ff   <= evicted_in;
   end

   // output stage: holds a finished beat while the sequencer takes the next
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff   <= status_ff;
         rsp_slot_ff     <= slot_ff;
         rsp_evicted_ff  <= evicted_ff;
         rsp_fallback_ff <= fallback_ff;
      end
   end

   assign req_ch.ready          = (state_ff == escp_pkg::S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.slot           = rsp_slot_ff;
   assign rsp_ch.evicted_expert = rsp_evicted_ff;
   assign rsp_ch.used_fallback  = rsp_fallback_ff;

   // ---------------------------------------------------------------
   // Submodules
   // ---------------------------------------------------------------
   escp_store u_store (
      .clock   (clock),
      .ctl     (ctl_m),
      .owner_q (owner_q),
      .stamp_q (stamp_q),
      .map_q   (map_q),
      .valid_q (valid_q)
   );

   escp_scan u_scan (
      .clock    (clock),
      .start    (state_ff == escp_pkg::S_PREP),
      .strobe   (issue_ff),
      .idx      (issue_idx_ff),
      .occupied (owner_q[escp_pkg::ID_W]),
      .stamp    (stamp_q),
      .chosen   (scan_slot)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_counter_only_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff != escp_pkg::S_EVAL) |=> $stable(counter_ff))
      else $error("use counter moved outside evaluation");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == escp_pkg::ST_REJECT)) |->
      ((rsp_ch.slot == '0) && !rsp_ch.used_fallback && (rsp_ch.evicted_expert == '0)))
      else $error("rejected beat carries slot data");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == escp_pkg::S_LOOKUP) && fallback_ff) |->
      ({1'b0, scan_slot} < count))
      else $error("search picked a slot beyond the effective count");
endmodule
